/* design/mfa_pkg.sv */
// ----------------------------------------------------------------------------
// mfa_pkg: shared types and constants for the mixed fraction ALU
// Action codes, status codes, default word size and the divider interface.
// ----------------------------------------------------------------------------
package mfa_pkg;

   localparam int DefWordBits = 32;
   localparam int WideBits    = 128;

   typedef enum logic [2:0] {
      ACT_ADD = 3'd0,
      ACT_SUB = 3'd1,
      ACT_MUL = 3'd2,
      ACT_DIV = 3'd3,
      ACT_CMP = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_DIV0  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      logic                start;
      logic [WideBits-1:0] dividend;
      logic [WideBits-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [WideBits-1:0] quotient;
      logic [WideBits-1:0] remainder;
   } div_rsp_type;

endpackage

/* design/mfa_divider.sv */
// ----------------------------------------------------------------------------
// mfa_divider: shared restoring divider
// Unsigned 128-bit divide, one quotient bit per cycle. Divisor zero gives
// quotient zero and remainder equal to the dividend.
// ----------------------------------------------------------------------------
module mfa_divider
   import mfa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [6:0]          cnt_ff, cnt_in;
   logic [WideBits-1:0] num_ff, num_in;
   logic [WideBits-1:0] den_ff, den_in;
   logic [WideBits-1:0] quo_ff, quo_in;
   logic [WideBits-1:0] rem_ff, rem_in;
   logic [WideBits:0]   shifted;
   logic [WideBits:0]   diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      shifted = {rem_ff, num_ff[WideBits-1]};
      diff    = shifted - {1'b0, den_ff};
      if (div_req.start) begin
         num_in = div_req.dividend;
         den_in = div_req.divisor;
         quo_in = '0;
         rem_in = '0;
         cnt_in = '0;
         if (div_req.divisor == '0) begin
            rem_in  = div_req.dividend;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         num_in = {num_ff[WideBits-2:0], 1'b0};
         if (!diff[WideBits]) begin
            rem_in = diff[WideBits-1:0];
            quo_in = {quo_ff[WideBits-2:0], 1'b1};
         end else begin
            rem_in = shifted[WideBits-1:0];
            quo_in = {quo_ff[WideBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(WideBits - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

   a_done_one_cycle: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff || $past(div_req.start))
      else $error("divider done held");
   a_busy_no_done: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !div_req.start |=> busy_ff || done_ff)
      else $error("divider stopped without done");
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      done_ff && den_ff != '0 |-> rem_ff < den_ff)
      else $error("remainder not below divisor");

endmodule

/* design/mixed_fraction_alu_top.sv */
// ----------------------------------------------------------------------------
// mixed_fraction_alu_top: rational arithmetic on two mixed fractions
// A compare needs no division. Each Euclid step, the two reductions and the
// final split all run on one 128-bit divider at one quotient bit per cycle,
// so GCD depth sets the latency. Multiplies run on one 32x32 multiplier, four
// partial products per 64x64 product. req_stall is high from acceptance
// until the result item has been taken.
// ----------------------------------------------------------------------------
module mixed_fraction_alu_top
   import mfa_pkg::*;
#(
   parameter int WORD_BITS = DefWordBits
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_action,
   input  logic signed [31:0]   req_a_whole,
   input  logic signed [31:0]   req_a_num,
   input  logic [30:0]          req_a_den,
   input  logic signed [31:0]   req_b_whole,
   input  logic signed [31:0]   req_b_num,
   input  logic [30:0]          req_b_den,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [31:0]   rsp_r_whole,
   output logic signed [31:0]   rsp_r_num,
   output logic [30:0]          rsp_r_den,
   output logic                 rsp_is_equal,
   output logic                 rsp_is_greater,
   output logic                 rsp_is_less,
   output logic [1:0]           rsp_status
);

   localparam logic [127:0] MaxPos = (128'd1 << (WORD_BITS - 1)) - 128'd1;

   typedef enum logic [4:0] {
      S_IDLE, S_IMPA, S_IMPB, S_MUL, S_COMB, S_GCD_GO, S_GCD_W,
      S_RN_GO, S_RN_W, S_RD_GO, S_RD_W, S_SP_GO, S_SP_W, S_OUT
   } state_type;

   state_type     state_ff, state_in;
   logic [2:0]    act_ff, act_in;
   logic signed [31:0] aw_ff, an_ff, bw_ff, bn_ff;
   logic [30:0]   ad_ff, bd_ff;
   logic          sa_ff, sa_in, sb_ff, sb_in, sr_ff, sr_in;
   logic [63:0]   ma_ff, ma_in, mb_ff, mb_in;
   logic [30:0]   da_ff, da_in, db_ff, db_in;
   logic [2:0]    mstep_ff, mstep_in;
   logic [1:0]    part_ff, part_in;
   logic [127:0]  p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic [127:0]  acc_ff, acc_in;
   logic [127:0]  ga_ff, ga_in, gb_ff, gb_in;
   logic [127:0]  num_ff, num_in, den_ff, den_in;
   logic [31:0]   rw_ff, rw_in, rn_ff, rn_in;
   logic [30:0]   rd_ff, rd_in;
   logic          eq_ff, eq_in, gt_ff, gt_in, lt_ff, lt_in;
   logic [1:0]    st_ff, st_in;

   logic [31:0]   mul_a, mul_b;
   logic [63:0]   mul_p;
   logic [63:0]   ox, oy;
   logic [127:0]  mag_sum;
   logic          s2;
   logic [63:0]   imp_w;
   logic [31:0]   imp_n;
   logic [30:0]   imp_d;
   logic signed [65:0] imp_v;
   logic [127:0]  qlim;
   div_req_type   div_req;
   div_rsp_type   div_rsp;

   mfa_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign mul_p = mul_a * mul_b;

   always_comb begin
      state_in = state_ff;
      act_in = act_ff;
      sa_in = sa_ff; sb_in = sb_ff; sr_in = sr_ff;
      ma_in = ma_ff; mb_in = mb_ff; da_in = da_ff; db_in = db_ff;
      mstep_in = mstep_ff; part_in = part_ff;
      p0_in = p0_ff; p1_in = p1_ff; p2_in = p2_ff; acc_in = acc_ff;
      ga_in = ga_ff; gb_in = gb_ff; num_in = num_ff; den_in = den_ff;
      rw_in = rw_ff; rn_in = rn_ff; rd_in = rd_ff;
      eq_in = eq_ff; gt_in = gt_ff; lt_in = lt_ff; st_in = st_ff;
      div_req = '0;
      mul_a = '0; mul_b = '0;
      ox = '0; oy = '0;
      imp_w = '0; imp_n = '0; imp_d = '0; imp_v = '0;
      mag_sum = '0; s2 = 1'b0;
      qlim = MaxPos + {127'd0, sr_ff};

      // operand pair for product slot part_ff
      case (part_ff)
         2'd0:    begin ox = ma_ff; oy = {33'd0, db_ff}; end
         2'd1:    begin ox = mb_ff; oy = {33'd0, da_ff}; end
         default: begin ox = {33'd0, da_ff}; oy = {33'd0, db_ff}; end
      endcase
      if (act_ff == ACT_MUL && part_ff == 2'd0) oy = mb_ff;
      if (act_ff == ACT_DIV && part_ff == 2'd1) begin
         ox = {33'd0, da_ff}; oy = mb_ff;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in = req_action;
               state_in = S_IMPA;
            end
         end
         S_IMPA, S_IMPB: begin
            if (state_ff == S_IMPA) begin
               imp_w = {{32{aw_ff[31]}}, aw_ff}; imp_n = an_ff; imp_d = ad_ff;
            end else begin
               imp_w = {{32{bw_ff[31]}}, bw_ff}; imp_n = bn_ff; imp_d = bd_ff;
            end
            if (imp_d == '0) imp_d = 31'd1;
            mul_a = imp_w[31:0];
            mul_b = {1'b0, imp_d};
            // signed w*d: correct unsigned product for negative w
            imp_v = $signed({2'b00, mul_p})
                  - (imp_w[63] ? $signed({3'b000, imp_d, 32'd0}) : 66'sd0)
                  + $signed({{34{imp_n[31]}}, imp_n});
            if (state_ff == S_IMPA) begin
               sa_in = imp_v[65];
               ma_in = imp_v[65] ? 64'(-imp_v) : imp_v[63:0];
               da_in = imp_d;
               state_in = S_IMPB;
            end else begin
               sb_in = imp_v[65];
               mb_in = imp_v[65] ? 64'(-imp_v) : imp_v[63:0];
               db_in = imp_d;
               mstep_in = '0; part_in = '0; acc_in = '0;
               state_in = S_MUL;
               if (act_ff > ACT_CMP) state_in = S_OUT;
               if (act_ff == ACT_DIV && (imp_v == '0)) begin
                  st_in = ST_DIV0;
                  state_in = S_OUT;
               end
            end
            eq_in = 1'b0; gt_in = 1'b0; lt_in = 1'b0;
            rw_in = '0; rn_in = '0; rd_in = 31'd1;
            if (state_ff == S_IMPA) st_in = ST_OK;
         end
         S_MUL: begin
            mul_a = mstep_ff[1] ? ox[63:32] : ox[31:0];
            mul_b = mstep_ff[0] ? oy[63:32] : oy[31:0];
            acc_in = acc_ff + ({64'd0, mul_p} << (32 * (32'(mstep_ff[0])
                                                     + 32'(mstep_ff[1]))));
            mstep_in = mstep_ff + 3'd1;
            if (mstep_ff == 3'd3) begin
               mstep_in = '0;
               acc_in = '0;
               part_in = part_ff + 2'd1;
               case (part_ff)
                  2'd0:    p0_in = acc_ff + ({64'd0, mul_p} << 64);
                  2'd1:    p1_in = acc_ff + ({64'd0, mul_p} << 64);
                  default: p2_in = acc_ff + ({64'd0, mul_p} << 64);
               endcase
               if (part_ff == 2'd2 || (act_ff == ACT_CMP && part_ff == 2'd1))
                  state_in = S_COMB;
            end
         end
         S_COMB: begin
            if (act_ff == ACT_MUL || act_ff == ACT_DIV) begin
               num_in = p0_ff;
               den_in = p1_ff;
               sr_in = sa_ff ^ sb_ff;
               if (act_ff == ACT_MUL) den_in = p2_ff;
            end else begin
               s2 = (act_ff == ACT_ADD) ? sb_ff : !sb_ff;
               if (mb_ff == '0) s2 = 1'b0;
               if (sa_ff == s2) begin
                  mag_sum = p0_ff + p1_ff; sr_in = sa_ff;
               end else if (p0_ff >= p1_ff) begin
                  mag_sum = p0_ff - p1_ff; sr_in = sa_ff;
               end else begin
                  mag_sum = p1_ff - p0_ff; sr_in = s2;
               end
               if (mag_sum == '0) sr_in = 1'b0;
               num_in = mag_sum;
               den_in = p2_ff;
            end
            if (act_ff == ACT_CMP) begin
               eq_in = (mag_sum == '0);
               lt_in = (mag_sum != '0) && sr_in;
               gt_in = (mag_sum != '0) && !sr_in;
               state_in = S_OUT;
            end else if (num_in == '0) begin
               state_in = S_OUT;
            end else begin
               ga_in = num_in;
               gb_in = den_in;
               state_in = S_GCD_GO;
            end
         end
         S_GCD_GO: begin
            if (gb_ff == '0) begin
               state_in = S_RN_GO;
            end else begin
               div_req.start = 1'b1;
               div_req.dividend = ga_ff;
               div_req.divisor = gb_ff;
               state_in = S_GCD_W;
            end
         end
         S_GCD_W: begin
            if (div_rsp.done) begin
               ga_in = gb_ff;
               gb_in = div_rsp.remainder;
               state_in = S_GCD_GO;
            end
         end
         S_RN_GO: begin
            div_req.start = 1'b1;
            div_req.dividend = num_ff;
            div_req.divisor = ga_ff;
            state_in = S_RN_W;
         end
         S_RN_W: begin
            if (div_rsp.done) begin
               num_in = div_rsp.quotient;
               state_in = S_RD_GO;
            end
         end
         S_RD_GO: begin
            div_req.start = 1'b1;
            div_req.dividend = den_ff;
            div_req.divisor = ga_ff;
            state_in = S_RD_W;
         end
         S_RD_W: begin
            if (div_rsp.done) begin
               den_in = div_rsp.quotient;
               state_in = S_SP_GO;
            end
         end
         S_SP_GO: begin
            div_req.start = 1'b1;
            div_req.dividend = num_ff;
            div_req.divisor = den_ff;
            state_in = S_SP_W;
         end
         S_SP_W: begin
            if (div_rsp.done) begin
               state_in = S_OUT;
               if (den_ff > MaxPos || div_rsp.quotient > qlim) begin
                  st_in = ST_RANGE;
               end else begin
                  rw_in = sr_ff ? 32'(-div_rsp.quotient) : div_rsp.quotient[31:0];
                  rn_in = sr_ff ? 32'(-div_rsp.remainder) : div_rsp.remainder[31:0];
                  rd_in = (div_rsp.remainder == '0) ? 31'd1 : den_ff[30:0];
               end
            end
         end
         S_OUT: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (state_ff == S_IDLE) begin
         aw_ff <= req_a_whole; an_ff <= req_a_num; ad_ff <= req_a_den;
         bw_ff <= req_b_whole; bn_ff <= req_b_num; bd_ff <= req_b_den;
      end
      act_ff <= act_in;
      sa_ff <= sa_in; sb_ff <= sb_in; sr_ff <= sr_in;
      ma_ff <= ma_in; mb_ff <= mb_in; da_ff <= da_in; db_ff <= db_in;
      mstep_ff <= mstep_in; part_ff <= part_in;
      p0_ff <= p0_in; p1_ff <= p1_in; p2_ff <= p2_in; acc_ff <= acc_in;
      ga_ff <= ga_in; gb_ff <= gb_in; num_ff <= num_in; den_ff <= den_in;
      rw_ff <= rw_in; rn_ff <= rn_in; rd_ff <= rd_in;
      eq_ff <= eq_in; gt_ff <= gt_in; lt_ff <= lt_in; st_ff <= st_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = (state_ff == S_OUT);
   assign rsp_r_whole    = rw_ff;
   assign rsp_r_num      = rn_ff;
   assign rsp_r_den      = rd_ff;
   assign rsp_is_equal   = eq_ff;
   assign rsp_is_greater = gt_ff;
   assign rsp_is_less    = lt_ff;
   assign rsp_status     = st_ff;

   a_flags_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({eq_ff, gt_ff, lt_ff}))
      else $error("compare flags not exclusive");
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rd_ff != '0)
      else $error("zero result denominator");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && st_ff != ST_OK |-> rw_ff == '0 && rn_ff == '0)
      else $error("error result not cleared");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while result pending");

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for the mixed fraction ALU
// Drives operand pairs with random idle and stall bursts, predicts each result
// with 128-bit arithmetic and compares every result field in order.
// ----------------------------------------------------------------------------
module tb_top;
   import mfa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WordBits = DefWordBits;

   typedef struct {
      logic signed [31:0] r_whole;
      logic signed [31:0] r_num;
      logic [30:0]        r_den;
      logic               is_equal;
      logic               is_greater;
      logic               is_less;
      logic [1:0]         status;
   } fraction_result;

   typedef logic [127:0] u128;

   int error_count = 0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $time);
      error_count++;
   endtask

   class fraction_scoreboard;
      fraction_result pending[$];
      int             checked = 0;

      function automatic void make_improper(input logic signed [31:0] whole,
            input logic signed [31:0] num, input logic [30:0] den_in,
            output bit neg, output u128 mag, output u128 den);
         longint d;
         longint v;
         d = (den_in == 0) ? 1 : longint'(den_in);
         v = longint'(whole) * d + longint'(num);
         neg = v < 0;
         mag = neg ? u128'(-v) : u128'(v);
         den = u128'(d);
      endfunction

      function automatic u128 euclid_gcd(input u128 a, input u128 b);
         u128 t;
         while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
         end
         return a;
      endfunction

      function automatic fraction_result compute_fraction(input logic [2:0] act,
            input logic signed [31:0] aw, input logic signed [31:0] an,
            input logic [30:0] ad, input logic signed [31:0] bw,
            input logic signed [31:0] bn, input logic [30:0] bd);
         fraction_result r;
         bit  sa, sb, s2, sr;
         u128 ma, da, mb, db, num, den, x, y, g, q, rem, maxpos;
         r = '{0, 0, 1, 0, 0, 0, ST_OK};
         sr = 0;
         maxpos = (u128'(1) << (WordBits - 1)) - 1;
         make_improper(aw, an, ad, sa, ma, da);
         make_improper(bw, bn, bd, sb, mb, db);
         case (act)
            ACT_ADD, ACT_SUB, ACT_CMP: begin
               s2 = (act == ACT_ADD) ? sb : !sb;
               if (mb == 0) s2 = 0;
               x = ma * db;
               y = mb * da;
               if (sa == s2) begin
                  sr = sa; num = x + y;
               end else if (x >= y) begin
                  sr = sa; num = x - y;
               end else begin
                  sr = s2; num = y - x;
               end
               if (num == 0) sr = 0;
               if (act == ACT_CMP) begin
                  if (num == 0) r.is_equal = 1;
                  else if (sr) r.is_less = 1;
                  else r.is_greater = 1;
                  return r;
               end
               den = da * db;
            end
            ACT_MUL: begin
               num = ma * mb; den = da * db; sr = sa != sb;
            end
            ACT_DIV: begin
               if (mb == 0) begin
                  r.status = ST_DIV0;
                  return r;
               end
               num = ma * db; den = da * mb; sr = sa != sb;
            end
            default: return r;
         endcase
         if (num == 0) return r;
         g = euclid_gcd(num, den);
         num = num / g;
         den = den / g;
         q = num / den;
         rem = num % den;
         if (den > maxpos || q > maxpos + (sr ? 1 : 0)) begin
            r.status = ST_RANGE;
            return r;
         end
         r.r_whole = sr ? -q[31:0] : q[31:0];
         r.r_num = sr ? -rem[31:0] : rem[31:0];
         r.r_den = (rem == 0) ? 31'd1 : den[30:0];
         return r;
      endfunction

      function void note_request(input logic [2:0] act, input logic signed [31:0] aw,
            input logic signed [31:0] an, input logic [30:0] ad,
            input logic signed [31:0] bw, input logic signed [31:0] bn,
            input logic [30:0] bd);
         pending.push_back(compute_fraction(act, aw, an, ad, bw, bn, bd));
      endfunction

      task check_result(input fraction_result got);
         fraction_result want;
         if (pending.size() == 0) begin
            report_mismatch("unexpected item", 0, 0);
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.r_whole !== want.r_whole)
            report_mismatch("r_whole", got.r_whole, want.r_whole);
         if (got.r_num !== want.r_num) report_mismatch("r_num", got.r_num, want.r_num);
         if (got.r_den !== want.r_den) report_mismatch("r_den", got.r_den, want.r_den);
         if (got.is_equal !== want.is_equal)
            report_mismatch("is_equal", got.is_equal, want.is_equal);
         if (got.is_greater !== want.is_greater)
            report_mismatch("is_greater", got.is_greater, want.is_greater);
         if (got.is_less !== want.is_less)
            report_mismatch("is_less", got.is_less, want.is_less);
         if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
      endtask
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic [2:0]         req_action = '0;
   logic signed [31:0] req_a_whole = '0, req_a_num = '0;
   logic signed [31:0] req_b_whole = '0, req_b_num = '0;
   logic [30:0]        req_a_den = '0, req_b_den = '0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic signed [31:0] rsp_r_whole, rsp_r_num;
   logic [30:0]        rsp_r_den;
   logic               rsp_is_equal, rsp_is_greater, rsp_is_less;
   logic [1:0]         rsp_status;

   fraction_scoreboard board = new();
   bit  calm = 0;
   bit  long_hold = 0;
   int  sent = 0;

   always #5 clock = ~clock;

   mixed_fraction_alu_top #(.WORD_BITS(WordBits)) DUT (.*);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result('{rsp_r_whole, rsp_r_num, rsp_r_den, rsp_is_equal,
                              rsp_is_greater, rsp_is_less, rsp_status});
   end

   // receiver stall bursts; one long hold-off on request
   initial begin
      int n;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1;
            repeat (3000) @(posedge clock);
            rsp_stall <= 0;
            long_hold = 0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 17);
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
            rsp_stall <= 0;
         end
      end
   end

   task automatic send_item(input logic [2:0] act, input logic signed [31:0] aw,
         input logic signed [31:0] an, input logic [30:0] ad,
         input logic signed [31:0] bw, input logic signed [31:0] bn,
         input logic [30:0] bd);
      req_valid <= 1;
      req_action <= act;
      req_a_whole <= aw; req_a_num <= an; req_a_den <= ad;
      req_b_whole <= bw; req_b_num <= bn; req_b_den <= bd;
      do @(posedge clock); while (req_stall);
      board.note_request(act, aw, an, ad, bw, bn, bd);
      sent++;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 20) - 10;
         2: return $urandom_range(0, 2000) - 1000;
         3: return 32'sh7fffffff - $urandom_range(0, 3);
         4: return 32'sh80000000 + $urandom_range(0, 3);
         default: return $urandom_range(0, 200000) - 100000;
      endcase
   endfunction

   function automatic logic [30:0] pick_den();
      case ($urandom_range(0, 5))
         0: return 31'($urandom);
         1: return 31'($urandom_range(0, 12));
         2: return 31'(32'h7fffffff - $urandom_range(0, 3));
         default: return 31'($urandom_range(1, 5000));
      endcase
   endfunction

   task automatic wait_drained();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [2:0] act;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_item(ACT_ADD, 1, 1, 2, 2, 1, 3);
      send_item(ACT_SUB, 1, 1, 2, 1, 1, 2);
      send_item(ACT_MUL, -2, 1, 3, 3, -1, 4);
      send_item(ACT_DIV, 1, 0, 0, 0, 0, 5);
      send_item(ACT_DIV, 3, 1, 2, -1, -1, 4);
      send_item(ACT_CMP, 1, 1, 2, 1, 2, 4);
      send_item(ACT_CMP, -1, 0, 1, 1, 0, 1);
      send_item(ACT_CMP, 5, 0, 1, -5, 0, 1);
      send_item(ACT_ADD, 0, 0, 0, 0, 0, 0);
      send_item(ACT_ADD, 2, 0, 1, 3, 0, 1);
      send_item(ACT_ADD, 32'sh7fffffff, 0, 1, 1, 0, 1);
      send_item(ACT_SUB, 32'sh80000000, 0, 1, 0, 0, 1);
      send_item(ACT_MUL, 32'sh80000000, 0, 1, 32'sh80000000, 0, 1);
      send_item(ACT_MUL, 32'sh80000000, 0, 1, 1, 0, 1);
      send_item(ACT_DIV, 1, 0, 31'h7fffffff, 32'sh7fffffff, 0, 1);
      send_item(ACT_DIV, 0, 1, 31'h7fffffff, 0, 1, 31'h7ffffffe);
      send_item(ACT_ADD, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff,
                32'sh80000000, 32'sh80000000, 31'h7fffffff);
      send_item(ACT_SUB, -1, -1, 2, 0, 0, 0);
      send_item(3'd5, 1, 1, 1, 1, 1, 1);
      send_item(3'd6, 0, 0, 0, 0, 0, 0);
      send_item(3'd7, -1, -1, 31'h7fffffff, -1, -1, 31'h7fffffff);
      send_item(ACT_MUL, 0, 7, 3, 5, 0, 1);
      wait_drained();

      long_hold = 1;
      for (int i = 0; i < 1430; i++) begin
         if (i == 700) wait_drained();
         if (i == 1300) calm = 1;
         act = ($urandom_range(0, 30) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
         send_item(act, pick_word(), pick_word(), pick_den(),
                   pick_word(), pick_word(), pick_den());
      end
      wait_drained();
      repeat (50) @(posedge clock);
      $display("Covered %0d items, %0d results checked: all actions, sign and range",
               sent, board.checked);
      $display("extremes, zero denominators, division by zero, unknown actions.");
      if (error_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #2000ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

/* files.f */
design/mfa_pkg.sv
design/mfa_divider.sv
design/mixed_fraction_alu_top.sv
test/tb_top.sv
